[rtl/mppt_pkg.sv]
// ----------------------------------------------------------------------------
// mppt_pkg - shared types and constants for the P&O tracker
// Payload structs, mode codes and register indexes.
// ----------------------------------------------------------------------------
package mppt_pkg;

  typedef struct packed {
    logic [15:0]        bus_word;
    logic signed [15:0] current_word;
  } in_item_t;

  typedef struct packed {
    logic [9:0] duty_code;
    logic [1:0] mode;
  } out_item_t;

  localparam logic [1:0] MODE_MEASURE = 2'd0;
  localparam logic [1:0] MODE_HOLD    = 2'd1;
  localparam logic [1:0] MODE_TRACK   = 2'd2;
  localparam logic [1:0] MODE_PROTECT = 2'd3;

  localparam logic [2:0] REG_WEIGHT = 3'd0;
  localparam logic [2:0] REG_STEP   = 3'd1;
  localparam logic [2:0] REG_FLOOR  = 3'd2;
  localparam logic [2:0] REG_CEIL   = 3'd3;
  localparam logic [2:0] REG_UVLO   = 3'd4;
  localparam logic [2:0] REG_OCL    = 3'd5;

  // shared multiplier operation selects
  typedef enum logic [2:0] {
    MUL_V_NEW, MUL_V_OLD, MUL_I_NEW, MUL_I_OLD, MUL_POWER, MUL_CODE, MUL_VOC
  } mul_op_t;

endpackage

[rtl/mppt_mul.sv]
// ----------------------------------------------------------------------------
// mppt_mul - shared registered signed multiplier
// 26x26 signed product.
// ----------------------------------------------------------------------------
module mppt_mul (
  input  logic               clk,
  input  logic signed [25:0] a,
  input  logic signed [25:0] b,
  output logic signed [51:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

[rtl/mppt_perturb_observe_controller.sv]
// ----------------------------------------------------------------------------
// mppt_perturb_observe_controller - perturb-and-observe MPPT duty controller
// Sequenced datapath around one shared registered multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  - in channel (in_valid/in_stall/in_data) carries one raw sensor pair per
//    request: bus voltage word and signed current word.
//  - out channel (out_valid/out_stall/out_data) returns exactly one duty code
//    and mode per request.
//  - APB port sets filter weight, perturb step, duty limits and thresholds;
//    write only while the block is idle.
//  - The first VOC_SAMPLES requests average the open-circuit voltage and
//    return duty 0 in measuring mode through S_MEAS and S_DONE; the last
//    one adds S_VOC and S_CODE (mean taken by reciprocal multiply).
//  - Later requests run filter, protection, hold check and tracking through
//    states S_VNEW to S_DONE around the one shared 26x26 multiplier
//    (filter products, power product, duty scaling run back to back).
//  - in_stall is high while a request is in flight; a new request is taken
//    only in S_IDLE. The result sits in an output register, so the next
//    request can start while it waits; a stalled result holds until taken
//    and the following one waits in its last state.
//  - Synchronous reset returns the control, configuration and tracker
//    registers to reset values and the tracker to measuring; no clearing pass.
// ----------------------------------------------------------------------------
module mppt_perturb_observe_controller #(
  parameter int VOC_SAMPLES = 10,
  parameter int DUTY_BITS   = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mppt_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mppt_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import mppt_pkg::*;

  localparam int CW = $clog2(VOC_SAMPLES + 1);
  localparam logic [CW-1:0] NSAMP = CW'(VOC_SAMPLES);
  localparam logic [25:0] FULL = 26'((1 << DUTY_BITS) - 1);
  // ceil(2^21 / N): exact floor(sum / N) for a 17-bit sum and N up to 15
  localparam logic [25:0] VOC_RECIP = 26'(((1 << 21) + VOC_SAMPLES - 1) / VOC_SAMPLES);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_MEAS   = 11'b00000000010,
    S_VOC    = 11'b00000000100,
    S_VNEW   = 11'b00000001000,
    S_VOLD   = 11'b00000010000,
    S_INEW   = 11'b00000100000,
    S_IOLD   = 11'b00001000000,
    S_CHECK  = 11'b00010000000,
    S_POWER  = 11'b00100000000,
    S_CODE   = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state;

  // configuration
  logic [8:0]  filter_weight;
  logic [15:0] perturb_step, duty_floor, duty_ceiling;
  logic [12:0] undervolt_limit;
  logic [14:0] overcurrent_limit;

  // tracker state
  logic [CW-1:0]      sample_count;
  logic [16:0]        voc_sum;
  logic [12:0]        open_volt;
  logic [20:0]        filt_volt;
  logic signed [23:0] filt_curr;
  logic [20:0]        last_volt;
  logic signed [44:0] last_power;
  logic [15:0]        track_duty;

  // per-request working registers
  in_item_t           req;
  logic signed [51:0] acc;
  logic [15:0]        duty_sel;
  logic [1:0]         mode_sel;
  logic               out_full;

  // shared multiplier
  logic signed [25:0] ma, mb;
  logic signed [51:0] mp;
  mul_op_t            op;

  mppt_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  logic [8:0]  w;
  logic [12:0] v;
  assign w = (filter_weight > 9'd256) ? 9'd256 : filter_weight;
  assign v = req.bus_word[15:3];

  always_comb begin
    ma = '0;
    mb = '0;
    case (op)
      // issued while idle, so the new voltage comes straight from the port
      MUL_V_NEW: begin ma = 26'(w); mb = 26'({in_data.bus_word[15:3], 8'd0}); end
      MUL_V_OLD: begin ma = 26'(9'd256 - w); mb = 26'(filt_volt); end
      MUL_I_NEW: begin ma = 26'(w); mb = 26'($signed({req.current_word, 8'd0})); end
      MUL_I_OLD: begin ma = 26'(9'd256 - w); mb = 26'(filt_curr); end
      MUL_POWER: begin ma = 26'(filt_volt); mb = 26'(filt_curr); end
      MUL_CODE:  begin ma = 26'(duty_sel); mb = FULL; end
      MUL_VOC:   begin ma = 26'(voc_sum); mb = VOC_RECIP; end
      default:   begin ma = '0; mb = '0; end
    endcase
  end

  // op is issued one state ahead of the product being consumed
  always_comb begin
    case (state)
      S_VOC:   op = MUL_VOC;
      S_VNEW:  op = MUL_V_OLD;
      S_VOLD:  op = MUL_I_NEW;
      S_INEW:  op = MUL_I_OLD;
      S_IOLD:  op = MUL_POWER;
      S_CHECK: op = MUL_POWER;
      S_POWER: op = MUL_CODE;
      S_CODE:  op = MUL_CODE;
      S_DONE:  op = MUL_CODE;
      default: op = MUL_V_NEW;
    endcase
  end

  // comparisons on the freshly filtered values
  logic [23:0] fv5, ov_hi, ov_lo;
  logic        prot, hold;
  assign fv5   = 24'(filt_volt) * 24'd5;
  assign ov_hi = 24'({open_volt, 8'd0}) * 24'd6;
  assign ov_lo = 24'({open_volt, 8'd0}) * 24'd3;
  assign prot  = (filt_volt < {undervolt_limit, 8'd0}) || (fv5 > ov_hi) ||
                 (filt_curr > $signed({1'b0, overcurrent_limit, 8'd0}));
  assign hold  = fv5 < ov_lo;

  logic signed [44:0] pw;
  logic signed [17:0] dsum;
  logic [15:0]        dsat, dclamp;
  logic               up;
  assign pw   = mp[44:0];
  assign up   = (pw > last_power) ? !(filt_volt < last_volt) == 1'b0
                                  : !(filt_volt < last_volt);
  assign dsum = up ? $signed({2'b0, track_duty}) + $signed({2'b0, perturb_step})
                   : $signed({2'b0, track_duty}) - $signed({2'b0, perturb_step});
  assign dsat = dsum < 0 ? 16'd0 : (dsum > 18'sd65535 ? 16'hFFFF : dsum[15:0]);
  always_comb begin
    dclamp = dsat;
    if (dclamp > duty_ceiling) dclamp = duty_ceiling;
    if (dclamp < duty_floor)   dclamp = duty_floor;
  end

  logic signed [51:0] isum;
  assign isum = acc + mp;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = out_full;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
      sample_count <= '0;
      voc_sum <= '0;
      open_volt <= '0;
      filt_volt <= '0;
      filt_curr <= '0;
      last_volt <= '0;
      last_power <= '0;
      track_duty <= 16'd3277;
      filter_weight <= 9'd51;
      perturb_step <= 16'd66;
      duty_floor <= 16'd3277;
      duty_ceiling <= 16'd39322;
      undervolt_limit <= 13'd500;
      overcurrent_limit <= 15'd20000;
    end else begin
      if (out_full && !out_stall) out_full <= 1'b0;
      if (psel && penable && pwrite) begin
        case (paddr[4:2])
          REG_WEIGHT: filter_weight <= pwdata[8:0];
          REG_STEP:   perturb_step <= pwdata[15:0];
          REG_FLOOR:  duty_floor <= pwdata[15:0];
          REG_CEIL:   duty_ceiling <= pwdata[15:0];
          REG_UVLO:   undervolt_limit <= pwdata[12:0];
          REG_OCL:    overcurrent_limit <= pwdata[14:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req <= in_data;
            state <= (sample_count < NSAMP) ? S_MEAS : S_VNEW;
          end
        end
        S_MEAS: begin
          voc_sum <= voc_sum + 17'(v);
          sample_count <= sample_count + 1'b1;
          duty_sel <= '0;
          mode_sel <= MODE_MEASURE;
          // last sample: mean through the multiplier, loaded in S_CODE
          state <= (sample_count + 1'b1 >= NSAMP) ? S_VOC : S_DONE;
          acc <= '0;
        end
        S_VOC: state <= S_CODE;
        S_VNEW: begin acc <= mp; state <= S_VOLD; end
        S_VOLD: begin
          filt_volt <= 21'(isum >>> 8);
          state <= S_INEW;
        end
        S_INEW: begin acc <= mp; state <= S_IOLD; end
        S_IOLD: begin
          filt_curr <= 24'(isum >>> 8);
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (prot) begin
            duty_sel <= duty_floor; mode_sel <= MODE_PROTECT; state <= S_POWER;
          end else if (hold) begin
            duty_sel <= duty_floor; mode_sel <= MODE_HOLD; state <= S_POWER;
          end else begin
            mode_sel <= MODE_TRACK; state <= S_POWER;
          end
        end
        S_POWER: begin
          // mp holds filt_volt*filt_curr here
          if (mode_sel == MODE_TRACK) begin
            track_duty <= dsat;
            last_volt <= filt_volt;
            last_power <= pw;
            duty_sel <= dclamp;
          end
          state <= S_CODE;
        end
        S_CODE: begin
          // measuring ends: mp holds voc_sum * VOC_RECIP
          if (mode_sel == MODE_MEASURE) begin
            open_volt <= mp[33:21];
            filt_volt <= {mp[33:21], 8'd0};
            filt_curr <= '0;
          end
          acc <= '0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_full || !out_stall) begin
            out_data.duty_code <= (mode_sel == MODE_MEASURE) ? 10'd0 : mp[25:16];
            out_data.mode <= mode_sel;
            out_full <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_WEIGHT: prdata = 32'(filter_weight);
      REG_STEP:   prdata = 32'(perturb_step);
      REG_FLOOR:  prdata = 32'(duty_floor);
      REG_CEIL:   prdata = 32'(duty_ceiling);
      REG_UVLO:   prdata = 32'(undervolt_limit);
      REG_OCL:    prdata = 32'(overcurrent_limit);
      default:    prdata = '0;
    endcase
  end
endmodule

[rtl/mppt_checker.sv]
// ----------------------------------------------------------------------------
// mppt_checker - port-level checks for the P&O tracker
// Handshake and output-range checks, bound to the top level.
// ----------------------------------------------------------------------------
module mppt_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mppt_pkg::out_item_t out_data
);
  import mppt_pkg::*;

  // one request in flight: after an accept the input side stalls
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("accept while busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_meas: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.mode == MODE_MEASURE |-> out_data.duty_code == 10'd0)
    else $error("nonzero duty while measuring");

  // a new result is loaded only from the busy side
  a_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall)) else $error("result without request");
endmodule

bind mppt_perturb_observe_controller mppt_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

[dv/mppt_po_checker.sv]
// ----------------------------------------------------------------------------
// mppt_po_checker - result predictor and scoreboard for the P&O tracker
// Watches both channels and the APB writes, keeps a copy of the tracker
// state, predicts duty code and mode per request and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mppt_po_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  mppt_pkg::in_item_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  mppt_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output int                   errors,
  output int                   pending,
  output int                   n_track,
  output int                   n_protect,
  output int                   n_hold
);
  import mppt_pkg::*;

  localparam int VOC_N = 10;

  // register copy
  logic [8:0]  weight_r;
  logic [15:0] step_r, floor_r, ceil_r;
  logic [12:0] uvlo_r;
  logic [14:0] ocl_r;

  // tracker state copy
  int unsigned      n_samples;
  logic [16:0]      voc_acc;
  logic [12:0]      voc;
  longint           v_filt, i_filt, v_prev, p_prev;
  logic [15:0]      duty_trk;

  out_item_t duty_q[$];

  function automatic longint div256_floor(longint x);
    if (x >= 0) return x / 256;
    return -((-x + 255) / 256);
  endfunction

  function automatic logic [9:0] duty_to_code(logic [15:0] d);
    longint unsigned full;
    full = 1023;
    return 10'(((longint'(d) * full) >> 16) & 10'h3ff);
  endfunction

  task automatic predict_duty(input in_item_t rq);
    longint v, i, w, ov8, pw, d;
    logic [15:0] dd;
    out_item_t r;
    v = longint'(rq.bus_word[15:3]);
    i = longint'(rq.current_word);
    w = (weight_r > 256) ? 256 : longint'(weight_r);
    ov8 = longint'(voc) << 8;
    if (n_samples < VOC_N) begin
      voc_acc = voc_acc + 17'(v);
      n_samples++;
      if (n_samples >= VOC_N) begin
        voc = 13'(voc_acc / VOC_N);
        v_filt = longint'(voc) << 8;
        i_filt = 0;
      end
      r.duty_code = '0;
      r.mode = MODE_MEASURE;
    end else begin
      v_filt = (w * (v << 8) + (256 - w) * v_filt) >> 8;
      i_filt = div256_floor(w * (i * 256) + (256 - w) * i_filt);
      if (v_filt < (longint'(uvlo_r) << 8) || 5 * v_filt > 6 * ov8 ||
          i_filt > (longint'(ocl_r) << 8)) begin
        r.duty_code = duty_to_code(floor_r);
        r.mode = MODE_PROTECT;
        n_protect++;
      end else if (5 * v_filt < 3 * ov8) begin
        r.duty_code = duty_to_code(floor_r);
        r.mode = MODE_HOLD;
        n_hold++;
      end else begin
        pw = v_filt * i_filt;
        d = longint'(duty_trk);
        if ((pw > p_prev) == (v_filt < v_prev)) d += step_r;
        else d -= step_r;
        if (d < 0) d = 0;
        if (d > 65535) d = 65535;
        duty_trk = 16'(d);
        v_prev = v_filt;
        p_prev = pw;
        dd = duty_trk;
        if (dd > ceil_r) dd = ceil_r;
        if (dd < floor_r) dd = floor_r;
        r.duty_code = duty_to_code(dd);
        r.mode = MODE_TRACK;
        n_track++;
      end
    end
    duty_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      weight_r <= 9'd51;
      step_r   <= 16'd66;
      floor_r  <= 16'd3277;
      ceil_r   <= 16'd39322;
      uvlo_r   <= 13'd500;
      ocl_r    <= 15'd20000;
      n_samples = 0;
      voc_acc = '0;
      voc = '0;
      v_filt = 0;
      i_filt = 0;
      v_prev = 0;
      p_prev = 0;
      duty_trk = 16'd3277;
      duty_q.delete();
      errors <= 0;
      n_track <= 0;
      n_protect <= 0;
      n_hold <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_WEIGHT: weight_r <= pwdata[8:0];
          REG_STEP:   step_r   <= pwdata[15:0];
          REG_FLOOR:  floor_r  <= pwdata[15:0];
          REG_CEIL:   ceil_r   <= pwdata[15:0];
          REG_UVLO:   uvlo_r   <= pwdata[12:0];
          REG_OCL:    ocl_r    <= pwdata[14:0];
          default: ;
        endcase
      end
      // result before request: a request accepted this edge cannot finish now
      if (out_valid && !out_stall) begin
        if (duty_q.size() == 0) begin
          report_mismatch("unexpected result, mode", out_data.mode, -1);
        end else begin
          e = duty_q.pop_front();
          if (out_data.duty_code !== e.duty_code)
            report_mismatch("duty_code", out_data.duty_code, e.duty_code);
          if (out_data.mode !== e.mode)
            report_mismatch("mode", out_data.mode, e.mode);
        end
      end
      if (in_valid && !in_stall) predict_duty(in_data);
    end
    pending <= duty_q.size();
  end
endmodule

[dv/mppt_perturb_observe_controller_tb.sv]
// ----------------------------------------------------------------------------
// mppt_perturb_observe_controller_tb - stimulus and verdict for the tracker
// Drives sensor pairs with random gaps and output stalls, reprograms the
// registers between phases over APB, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mppt_perturb_observe_controller_tb;
  import mppt_pkg::*;

  logic       clk, rst;
  logic       in_valid, in_stall, out_valid, out_stall;
  in_item_t   in_data;
  out_item_t  out_data;
  logic       psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  int errors, pending, n_track, n_protect, n_hold;
  int n_sent;
  bit stall_en;

  mppt_perturb_observe_controller u_dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mppt_po_checker u_chk (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .pending, .n_track, .n_protect, .n_hold
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // hard stop, well past the slowest legal run
  initial begin
    #50ms;
    $display("mppt_perturb_observe_controller_tb: errors");
    $finish;
  end

  // gap length: mostly short, sometimes long
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // receiver stalls; stall_en off gives stretches of full throughput
  always @(posedge clk) begin
    if (rst || !stall_en) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 9) < 3);
  end

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [15:0] bw, input logic [15:0] cw);
    int g;
    g = gap_len();
    in_valid <= 1'b1;
    in_data <= '{bus_word: bw, current_word: cw};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    // no gap: valid stays up and the next call drives the new pair
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic warm_up(input int vmid);
    repeat (10) send_sample(16'((vmid + $urandom_range(0, 20)) << 3), 16'($urandom));
  endtask

  // random request: mostly near the tracking window around Voc
  task automatic random_sample(input int vmid);
    int v, c;
    case ($urandom_range(0, 9))
      0: begin v = $urandom_range(0, 8191); c = $urandom_range(0, 65535); end
      1: begin v = vmid / 2; c = $urandom_range(0, 3000); end
      2: begin v = vmid * 13 / 10; c = $urandom_range(0, 3000); end
      default: begin
        v = vmid * 8 / 10 + $urandom_range(0, vmid / 4);
        c = $urandom_range(0, 25000);
      end
    endcase
    if (v > 8191) v = 8191;
    send_sample({13'(v), 3'($urandom)}, 16'(c));
  endtask

  task automatic set_regs(input logic [31:0] w, s, f, ce, u, o);
    apb_write(REG_WEIGHT, w);
    apb_write(REG_STEP, s);
    apb_write(REG_FLOOR, f);
    apb_write(REG_CEIL, ce);
    apb_write(REG_UVLO, u);
    apb_write(REG_OCL, o);
  endtask

  initial begin
    rst = 1'b1; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    n_sent = 0; stall_en = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes during measuring, then corner cases at reset regs
    send_sample(16'hffff, 16'h8000);
    send_sample(16'h0000, 16'h7fff);
    send_sample(16'h0007, 16'hffff);
    repeat (7) send_sample(16'd2000 << 3, 16'd0);
    send_sample(16'd2000 << 3, 16'd1000);        // tracking
    send_sample(16'd2100 << 3, 16'd1200);
    send_sample(16'd1900 << 3, 16'd800);
    send_sample(16'd100 << 3, 16'd0);            // undervoltage
    send_sample(16'hfff8, 16'd0);                // overvoltage
    send_sample(16'd2000 << 3, 16'h7fff);        // overcurrent
    send_sample(16'd2000 << 3, 16'h8000);        // strongly negative current
    repeat (4) send_sample(16'd1000 << 3, 16'd500); // low-voltage hold
    drain();

    // phases with different register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      int vmid;
      case (ph)
        0: set_regs(256, 65535, 0, 65535, 0, 32767);
        1: set_regs(511, 1, 65535, 0, 8191, 0);
        2: set_regs(0, 0, 3277, 39322, 500, 20000);
        3: set_regs(300, 4000, 40000, 20000, 100, 10000);
        default: set_regs($urandom_range(1, 511), $urandom_range(0, 65535) >> $urandom_range(0, 12),
                          $urandom_range(0, 8000), $urandom_range(20000, 65535),
                          $urandom_range(0, 1000), $urandom_range(5000, 32767));
      endcase
      apb_write(3'd7, 32'hffff_ffff);   // unmapped index, ignored
      rst <= (ph == 99);                // never true; reset stays released
      stall_en = ph[0];
      vmid = (ph == 1) ? 8000 : $urandom_range(1500, 4000);
      warm_up(vmid);
      repeat (170) begin
        if ($urandom_range(0, 9) < 6) stall_en = $urandom_range(0, 1);
        random_sample(vmid);
      end
      drain();   // sender holds off until every result is back
    end

    $display("sent %0d sensor pairs over 8 register settings", n_sent);
    $display("results: %0d tracking, %0d protection, %0d hold", n_track, n_protect, n_hold);
    if (errors == 0) begin
      $display("mppt_perturb_observe_controller_tb: clean");
    end else begin
      $display("mppt_perturb_observe_controller_tb: errors");
    end
    $finish;
  end
endmodule
